// ===== rtl/crrt_pkg.sv =====
// Shared types and codes for the connection redirect rule table.
package crrt_pkg;

	typedef enum logic [1:0] {
		ACT_ADD_RULE = 2'd0,
		ACT_REMEMBER = 2'd1,
		ACT_LOOKUP   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		STAT_RULE_HIT     = 3'd0,
		STAT_RESOLVED_HIT = 3'd1,
		STAT_MISS         = 3'd2,
		STAT_STORED       = 3'd3,
		STAT_INVALID      = 3'd4,
		STAT_FULL         = 3'd5,
		STAT_DUPLICATE    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RULE,
		ST_RES,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] remote_addr;
		logic [15:0] remote_port;
		logic        any_host;
		logic [31:0] local_addr;
		logic [15:0] local_port;
	} rule_ent_t;

	typedef struct packed {
		logic [15:0] remote_port;
		logic [31:0] local_addr;
		logic [15:0] local_port;
	} res_ent_t;

	typedef struct packed {
		logic        sel_rule;
		logic [31:0] key_addr;
		logic [15:0] key_port;
	} match_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] addr;
		logic [15:0] port;
	} result_t;

endpackage

// ===== rtl/crrt_match.sv =====
// Shared entry compare unit used for both the rule scan and the resolved scan.
module crrt_match (
	input  crrt_pkg::match_req_t req,
	input  crrt_pkg::rule_ent_t  rule,
	input  crrt_pkg::res_ent_t   res,
	output logic                 hit
);

	logic [15:0] port_a;
	logic [31:0] addr_a;
	logic        wild;

	always_comb begin
		if (req.sel_rule) begin
			port_a = rule.remote_port;
			addr_a = rule.remote_addr;
			wild   = rule.any_host | (rule.remote_addr == 32'd0);
		end else begin
			port_a = res.remote_port;
			addr_a = res.local_addr;
			wild   = 1'b0;
		end
		hit = (port_a == req.key_port) & (wild | (addr_a == req.key_addr));
	end

endmodule

// ===== rtl/connection_redirect_rule_table.sv =====
// Top level of the connection redirect rule table with its sequencer and entry memories.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    action is_ipv4 dest_addr dest_port any_host
//                                             local_addr local_port
// out       source     out_valid / out_stall  status new_addr new_port
// cfg       sink       cfg_valid / cfg_ready  cfg_data (redirect_enabled)
//
// Adding a rule or an item rejected on entry goes through the result register to the output register.
// Remembering an entry scans the resolved table; a lookup scans the rule table and then the
// resolved table, stopping at the first hit.
// Each scan reads one memory entry per cycle into one compare unit.
// Reset empties both tables by clearing their counts and sets redirect_enabled.
// A finished result waits in the output register while the next transaction is accepted.
module connection_redirect_rule_table #(
	parameter int MAX_RULES    = 16,
	parameter int MAX_RESOLVED = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic        is_ipv4,
	input  logic [31:0] dest_addr,
	input  logic [15:0] dest_port,
	input  logic        any_host,
	input  logic [31:0] local_addr,
	input  logic [15:0] local_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] new_addr,
	output logic [15:0] new_port,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int RCNT_W = $clog2(MAX_RULES + 1);
	localparam int SCNT_W = $clog2(MAX_RESOLVED + 1);
	localparam int RI_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int SI_W   = (MAX_RESOLVED > 1) ? $clog2(MAX_RESOLVED) : 1;
	localparam int SCAN_W = (RCNT_W > SCNT_W) ? RCNT_W : SCNT_W;

	crrt_pkg::state_t    state_q, state_d;
	logic [SCAN_W-1:0]   scan_q, scan_d;
	logic [RCNT_W-1:0]   rule_count_q;
	logic [SCNT_W-1:0]   res_count_q;
	logic                enabled_q;
	logic                in_acc;
	logic                item_ld;
	logic                lookup_q;
	logic [31:0]         key_addr_q;
	logic [15:0]         key_port_q;
	logic [15:0]         local_port_q;
	logic                rule_rd_en, res_rd_en;
	logic                rule_we, res_we;
	logic                rd_vld_s1;
	crrt_pkg::rule_ent_t rule_mem [MAX_RULES];
	crrt_pkg::res_ent_t  res_mem [MAX_RESOLVED];
	crrt_pkg::rule_ent_t rule_rd_s1, rule_wr;
	crrt_pkg::res_ent_t  res_rd_s1, res_wr;
	crrt_pkg::match_req_t match_req;
	logic                hit;
	crrt_pkg::result_t   result_q, result_d;
	logic                result_ld;
	logic                out_ld;
	logic                out_valid_q;
	crrt_pkg::result_t   out_q;

	assign in_acc    = in_valid & ~in_stall;
	assign in_stall  = (state_q != crrt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign new_addr  = out_q.addr;
	assign new_port  = out_q.port;

	assign rule_wr = '{remote_addr: dest_addr, remote_port: dest_port, any_host: any_host,
		local_addr: local_addr, local_port: local_port};
	assign res_wr  = '{remote_port: key_port_q, local_addr: key_addr_q, local_port: local_port_q};

	assign match_req = '{sel_rule: (state_q == crrt_pkg::ST_RULE), key_addr: key_addr_q,
		key_port: key_port_q};

	crrt_match u_match (
		.req  (match_req),
		.rule (rule_rd_s1),
		.res  (res_rd_s1),
		.hit  (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		item_ld    = 1'b0;
		rule_rd_en = 1'b0;
		res_rd_en  = 1'b0;
		rule_we    = 1'b0;
		res_we     = 1'b0;
		result_ld  = 1'b0;
		result_d   = '{status: crrt_pkg::STAT_MISS, addr: 32'd0, port: 16'd0};
		out_ld     = 1'b0;
		unique case (state_q)
			crrt_pkg::ST_IDLE: begin
				if (in_acc) begin
					item_ld = 1'b1;
					scan_d  = '0;
					case (crrt_pkg::action_t'(action))
						crrt_pkg::ACT_ADD_RULE: begin
							result_ld = 1'b1;
							if (dest_port == 16'd0 || local_port == 16'd0) begin
								result_d.status = crrt_pkg::STAT_INVALID;
							end else if (rule_count_q >= RCNT_W'(MAX_RULES)) begin
								result_d.status = crrt_pkg::STAT_FULL;
							end else begin
								rule_we         = 1'b1;
								result_d.status = crrt_pkg::STAT_STORED;
							end
							state_d = crrt_pkg::ST_DONE;
						end
						crrt_pkg::ACT_REMEMBER: begin
							state_d = crrt_pkg::ST_RES;
						end
						crrt_pkg::ACT_LOOKUP: begin
							if (!enabled_q || !is_ipv4) begin
								result_ld       = 1'b1;
								result_d.status = crrt_pkg::STAT_MISS;
								state_d         = crrt_pkg::ST_DONE;
							end else begin
								state_d = crrt_pkg::ST_RULE;
							end
						end
						default: begin
							result_ld       = 1'b1;
							result_d.status = crrt_pkg::STAT_INVALID;
							state_d         = crrt_pkg::ST_DONE;
						end
					endcase
				end
			end
			crrt_pkg::ST_RULE: begin
				rule_rd_en = (scan_q < SCAN_W'(rule_count_q));
				if (rule_rd_en) begin
					scan_d = scan_q + SCAN_W'(1);
				end
				if (rd_vld_s1 && hit) begin
					result_ld = 1'b1;
					result_d  = '{status: crrt_pkg::STAT_RULE_HIT, addr: rule_rd_s1.local_addr,
						port: rule_rd_s1.local_port};
					state_d   = crrt_pkg::ST_DONE;
				end else if (!rule_rd_en && !rd_vld_s1) begin
					scan_d  = '0;
					state_d = crrt_pkg::ST_RES;
				end
			end
			crrt_pkg::ST_RES: begin
				res_rd_en = (scan_q < SCAN_W'(res_count_q));
				if (res_rd_en) begin
					scan_d = scan_q + SCAN_W'(1);
				end
				if (rd_vld_s1 && hit) begin
					result_ld = 1'b1;
					if (lookup_q) begin
						result_d = '{status: crrt_pkg::STAT_RESOLVED_HIT,
							addr: res_rd_s1.local_addr, port: res_rd_s1.local_port};
					end else begin
						result_d.status = crrt_pkg::STAT_DUPLICATE;
					end
					state_d = crrt_pkg::ST_DONE;
				end else if (!res_rd_en && !rd_vld_s1) begin
					result_ld = 1'b1;
					if (lookup_q) begin
						result_d.status = crrt_pkg::STAT_MISS;
					end else if (res_count_q >= SCNT_W'(MAX_RESOLVED)) begin
						result_d.status = crrt_pkg::STAT_FULL;
					end else begin
						res_we          = 1'b1;
						result_d.status = crrt_pkg::STAT_STORED;
					end
					state_d = crrt_pkg::ST_DONE;
				end
			end
			crrt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = crrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			rule_count_q <= '0;
			res_count_q  <= '0;
			enabled_q    <= 1'b1;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			scan_q    <= scan_d;
			rd_vld_s1 <= rule_rd_en | res_rd_en;
			if (cfg_valid && cfg_ready) begin
				enabled_q <= cfg_data;
			end
			if (rule_we) begin
				rule_count_q <= rule_count_q + RCNT_W'(1);
			end
			if (res_we) begin
				res_count_q <= res_count_q + SCNT_W'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ld) begin
			lookup_q     <= (action == crrt_pkg::ACT_LOOKUP);
			key_addr_q   <= (action == crrt_pkg::ACT_REMEMBER) ? local_addr : dest_addr;
			key_port_q   <= dest_port;
			local_port_q <= local_port;
		end
		if (result_ld) begin
			result_q <= result_d;
		end
		if (out_ld) begin
			out_q <= result_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[rule_count_q[RI_W-1:0]] <= rule_wr;
		end
		if (rule_rd_en) begin
			rule_rd_s1 <= rule_mem[scan_q[RI_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_count_q[SI_W-1:0]] <= res_wr;
		end
		if (res_rd_en) begin
			res_rd_s1 <= res_mem[scan_q[SI_W-1:0]];
		end
	end

	a_rule_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rule_count_q <= RCNT_W'(MAX_RULES))
		else $error("Rule count exceeds the table depth.");

	a_res_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_count_q <= SCNT_W'(MAX_RESOLVED))
		else $error("Resolved count exceeds the table depth.");

	a_rule_add: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == crrt_pkg::ACT_ADD_RULE && dest_port != 16'd0 &&
			local_port != 16'd0 && rule_count_q < RCNT_W'(MAX_RULES))
		|=> rule_count_q == $past(rule_count_q) + RCNT_W'(1))
		else $error("A stored rule did not advance the rule count.");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crrt_pkg::ST_RULE) |-> scan_q <= SCAN_W'(rule_count_q))
		else $error("Rule scan ran past the rule count.");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == crrt_pkg::ST_DONE))
		else $error("Output transaction raised outside the done state.");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the connection redirect rule table.
`timescale 1ns / 100ps

module tb;

	localparam int RULE_SLOTS = 16;
	localparam int ENTRY_SLOTS = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  act;
		logic        ipv4;
		logic [31:0] daddr;
		logic [15:0] dport;
		logic        anyh;
		logic [31:0] laddr;
		logic [15:0] lport;
	} redirect_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic        is_ipv4;
	logic [31:0] dest_addr;
	logic [15:0] dest_port;
	logic        any_host;
	logic [31:0] local_addr;
	logic [15:0] local_port;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] new_addr;
	logic [15:0] new_port;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// Shadow copy of the two tables and the enable register.
	logic        redirect_on;
	int          rules_held;
	logic [31:0] rule_raddr [RULE_SLOTS];
	logic [15:0] rule_rport [RULE_SLOTS];
	logic        rule_anyh  [RULE_SLOTS];
	logic [31:0] rule_laddr [RULE_SLOTS];
	logic [15:0] rule_lport [RULE_SLOTS];
	int          entries_held;
	logic [15:0] entry_rport [ENTRY_SLOTS];
	logic [31:0] entry_laddr [ENTRY_SLOTS];
	logic [15:0] entry_lport [ENTRY_SLOTS];

	crrt_pkg::result_t pending_results [$];
	int          mismatches = 0;
	int          stall_mode = 0;
	int          stall_span = 0;

	logic [31:0] host_pool [6] = '{32'h0A000001, 32'h0A000002, 32'hC0A80001,
		32'h08080808, 32'h7F000001, 32'hAC100001};
	logic [15:0] port_pool [12] = '{16'd80, 16'd443, 16'd22, 16'd8080, 16'd25, 16'd53,
		16'd110, 16'd143, 16'd993, 16'd3306, 16'd5432, 16'd6379};

	connection_redirect_rule_table #(
		.MAX_RULES(RULE_SLOTS),
		.MAX_RESOLVED(ENTRY_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.is_ipv4(is_ipv4),
		.dest_addr(dest_addr),
		.dest_port(dest_port),
		.any_host(any_host),
		.local_addr(local_addr),
		.local_port(local_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.new_addr(new_addr),
		.new_port(new_port),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic crrt_pkg::result_t predict_redirect(input redirect_req_t r);
		crrt_pkg::result_t res;
		logic    found;
		res.status = crrt_pkg::STAT_INVALID;
		res.addr = '0;
		res.port = '0;
		found = 1'b0;
		case (r.act)
			crrt_pkg::ACT_ADD_RULE: begin
				if (r.dport == 16'd0 || r.lport == 16'd0) begin
					res.status = crrt_pkg::STAT_INVALID;
				end else if (rules_held >= RULE_SLOTS) begin
					res.status = crrt_pkg::STAT_FULL;
				end else begin
					rule_raddr[rules_held] = r.daddr;
					rule_rport[rules_held] = r.dport;
					rule_anyh[rules_held] = r.anyh;
					rule_laddr[rules_held] = r.laddr;
					rule_lport[rules_held] = r.lport;
					rules_held++;
					res.status = crrt_pkg::STAT_STORED;
				end
			end
			crrt_pkg::ACT_REMEMBER: begin
				for (int i = 0; i < entries_held; i++)
					if (entry_laddr[i] == r.laddr && entry_rport[i] == r.dport)
						found = 1'b1;
				if (found) begin
					res.status = crrt_pkg::STAT_DUPLICATE;
				end else if (entries_held >= ENTRY_SLOTS) begin
					res.status = crrt_pkg::STAT_FULL;
				end else begin
					entry_rport[entries_held] = r.dport;
					entry_laddr[entries_held] = r.laddr;
					entry_lport[entries_held] = r.lport;
					entries_held++;
					res.status = crrt_pkg::STAT_STORED;
				end
			end
			crrt_pkg::ACT_LOOKUP: begin
				res.status = crrt_pkg::STAT_MISS;
				if (redirect_on && r.ipv4) begin
					for (int i = 0; i < rules_held; i++)
						if (!found && rule_rport[i] == r.dport && (rule_anyh[i] ||
								rule_raddr[i] == 32'd0 || rule_raddr[i] == r.daddr)) begin
							found = 1'b1;
							res.status = crrt_pkg::STAT_RULE_HIT;
							res.addr = rule_laddr[i];
							res.port = rule_lport[i];
						end
					for (int i = 0; i < entries_held; i++)
						if (!found && entry_rport[i] == r.dport &&
								entry_laddr[i] == r.daddr) begin
							found = 1'b1;
							res.status = crrt_pkg::STAT_RESOLVED_HIT;
							res.addr = entry_laddr[i];
							res.port = entry_lport[i];
						end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic redirect_req_t make_req(input logic [1:0] act, input logic ipv4,
			input logic [31:0] daddr, input logic [15:0] dport, input logic anyh,
			input logic [31:0] laddr, input logic [15:0] lport);
		redirect_req_t r;
		r.act = act;
		r.ipv4 = ipv4;
		r.daddr = daddr;
		r.dport = dport;
		r.anyh = anyh;
		r.laddr = laddr;
		r.lport = lport;
		return r;
	endfunction

	function automatic logic [31:0] pick_host();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 32'd0;
		if (k == 1)
			return 32'hFFFFFFFF;
		if (k < 4)
			return $urandom;
		return host_pool[$urandom_range(0, 5)];
	endfunction

	function automatic logic [15:0] pick_port(input int lo, input int hi);
		int k;
		k = $urandom_range(0, 11);
		if (k == 0)
			return 16'd0;
		if (k == 1)
			return 16'hFFFF;
		if (k == 2)
			return 16'($urandom_range(0, 65535));
		return port_pool[$urandom_range(lo, hi)];
	endfunction

	function automatic redirect_req_t random_request();
		redirect_req_t r;
		int pick;
		int idx;
		r = make_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
			16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), $urandom,
			16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			r.act = crrt_pkg::ACT_ADD_RULE;
			r.daddr = pick_host();
			r.dport = pick_port(0, 7);
			r.anyh = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				r.lport = 16'd0;
		end else if (pick < 24) begin
			r.act = crrt_pkg::ACT_REMEMBER;
			r.dport = pick_port(4, 11);
			r.laddr = pick_host();
		end else if (pick < 27) begin
			r.act = ACT_UNUSED;
		end else begin
			r.act = crrt_pkg::ACT_LOOKUP;
			r.ipv4 = ($urandom_range(0, 7) != 0);
			pick = $urandom_range(0, 9);
			if (pick < 4 && rules_held > 0) begin
				idx = $urandom_range(0, rules_held - 1);
				r.dport = rule_rport[idx];
				r.daddr = $urandom_range(0, 1) ? rule_raddr[idx] : pick_host();
			end else if (pick < 7 && entries_held > 0) begin
				idx = $urandom_range(0, entries_held - 1);
				r.dport = entry_rport[idx];
				r.daddr = entry_laddr[idx];
			end else begin
				r.dport = pick_port(0, 11);
				r.daddr = pick_host();
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(input redirect_req_t r);
		crrt_pkg::result_t expected;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= r.act;
		is_ipv4 <= r.ipv4;
		dest_addr <= r.daddr;
		dest_port <= r.dport;
		any_host <= r.anyh;
		local_addr <= r.laddr;
		local_port <= r.lport;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected = predict_redirect(r);
		pending_results.insert(pending_results.size(), expected);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_redirect_enable(input logic on);
		wait_all_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= on;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		redirect_on = on;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count, input bit steady);
		int burst;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (!steady && burst == 0) begin
				pause_sender($urandom_range(1, 12));
				burst = $urandom_range(1, 24);
			end
			send_request(random_request());
			if (burst > 0)
				burst--;
		end
	endtask

	task automatic test_directed_cases();
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h0A000001, 16'd80, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(ACT_UNUSED, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
			32'hFFFFFFFF, 16'hFFFF));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b1, 32'h0A000001, 16'd0, 1'b0,
			32'hC0A80001, 16'd8080));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b1, 32'h0A000001, 16'd80, 1'b0,
			32'hC0A80001, 16'd0));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b0, 32'h0A000001, 16'd80, 1'b1,
			32'hC0A80001, 16'd8080));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b0, 32'h00000000, 16'd443, 1'b0,
			32'hC0A80002, 16'd8443));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b0,
			32'hFFFFFFFF, 16'hFFFF));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b1, 32'h0A000005, 16'd80, 1'b0,
			32'hC0A80005, 16'd8005));
		send_request(make_req(crrt_pkg::ACT_ADD_RULE, 1'b1, 32'h0A000009, 16'd22, 1'b0,
			32'h7F000001, 16'd2222));
		send_request(make_req(crrt_pkg::ACT_REMEMBER, 1'b0, 32'd0, 16'd0, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_REMEMBER, 1'b0, 32'd0, 16'd0, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_REMEMBER, 1'b1, 32'd0, 16'd53, 1'b0,
			32'h08080808, 16'd5353));
		send_request(make_req(crrt_pkg::ACT_REMEMBER, 1'b1, 32'd0, 16'd22, 1'b0,
			32'h0A000007, 16'd7022));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h0A0000FF, 16'd80, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h0A000005, 16'd80, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h01020304, 16'd443, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h0A000009, 16'd22, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h0A000007, 16'd22, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h08080808, 16'd53, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h00000000, 16'd0, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b0, 32'h08080808, 16'd53, 1'b0,
			32'd0, 16'd0));
		send_request(make_req(crrt_pkg::ACT_LOOKUP, 1'b1, 32'h08080809, 16'd53, 1'b0,
			32'd0, 16'd0));
	endtask

	task automatic test_table_fill();
		write_redirect_enable(1'b1);
		run_random(700, 1'b0);
	endtask

	task automatic test_lookup_disabled();
		write_redirect_enable(1'b0);
		run_random(150, 1'b0);
	endtask

	task automatic test_back_to_back();
		write_redirect_enable(1'b1);
		run_random(300, 1'b1);
		run_random(400, 1'b0);
	endtask

	task automatic test_enable_toggle();
		write_redirect_enable(1'b0);
		run_random(100, 1'b1);
		write_redirect_enable(1'b1);
		run_random(300, 1'b0);
	endtask

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(40, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		crrt_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction status", 32'(status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (new_addr !== want.addr)
					report_mismatch("new_addr", new_addr, want.addr);
				if (new_port !== want.port)
					report_mismatch("new_port", 32'(new_port), 32'(want.port));
			end
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = crrt_pkg::ACT_ADD_RULE;
		is_ipv4 = 1'b0;
		dest_addr = '0;
		dest_port = '0;
		any_host = 1'b0;
		local_addr = '0;
		local_port = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		redirect_on = 1'b1;
		rules_held = 0;
		entries_held = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_table_fill();
		test_lookup_disabled();
		test_back_to_back();
		test_enable_toggle();

		wait_all_results();
		repeat (60)
			@(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
